[rtl/bxf_pkg.sv]
`timescale 1ns / 1ps

package bxf_pkg;

   // line buffer geometry
   localparam int MAX_WIDTH = 256;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = 16;
   localparam int PIX_W     = 8;

   // configuration register fields
   localparam int CFG_WIDTH_W  = 9;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // nine 8-bit pixels sum to at most 2295
   localparam int SUM_W = 12;

   // floor(x / 9) = (x * 3641) >> 15 for every x below 4096
   localparam int                RECIP_W     = 12;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 12'd3641;
   localparam int                RECIP_SHIFT = 15;
   localparam int                PROD_W      = SUM_W + RECIP_W;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   typedef struct packed {
      logic             frame_end;
      logic             row_end;
      logic [PIX_W-1:0] smoothed;
   } rsp_item_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   full;
   } queue_status_type;

endpackage

[rtl/box_filter_3x3_mean_unit.sv]
`timescale 1ns / 1ps

// 3x3 box filter: takes 8-bit grayscale pixels in raster order, one per cycle
// while req_tready is high, and for every interior pixel gives floor(sum of its
// 3x3 neighbourhood / 9); the one-pixel border gives no result. A pixel reaches
// the result queue by these steps: line-buffer read at acceptance, window sum
// with write-back, then reciprocal multiply into the queue. The rate is set by
// the two line buffers, each a single memory with one read and one write per
// cycle; no forwarding is needed because an entry is read again only a full row
// (at least three pixels) after its previous read, and its write-back lands in
// the cycle after that read. The line buffers have no clearing pass: entries
// never written are read only in the first two rows, which give no result.
// rsp_tlast marks the last result of a row, rsp_tuser the last of the frame. A
// configuration write restarts the frame; width saturates to 3..256 and height
// to at least 3. req_tready falls only when the entries of the four-entry result
// queue plus the pixels in the pipeline reach the queue depth.
module box_filter_3x3_mean_unit
   import bxf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // pixel stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] pixel_in
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] smoothed
   output logic                   rsp_tlast,   // row_end
   output logic [0:0]             rsp_tuser,   // [0] frame_end
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // effective geometry, kept as last column / last row
   logic [COL_W-1:0] width_last_ff;
   logic [COL_W-1:0] width_last_in;
   logic [ROW_W-1:0] height_last_ff;
   logic [ROW_W-1:0] height_last_in;

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             req_accept;
   logic             csr_accept;
   logic             last_col;
   logic             last_row;

   // line buffers
   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] up_rd_ff;
   logic [PIX_W-1:0] mid_rd_ff;

   // stage 1: read data back, window sum
   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic             s1_row_end_ff;
   logic             s1_frame_end_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_px_ff;
   logic [PIX_W-1:0] win_ff [6];
   logic [SUM_W-1:0] sum_in;

   // stage 2: divide by nine
   logic             s2_valid_ff;
   logic             s2_row_end_ff;
   logic             s2_frame_end_ff;
   logic [SUM_W-1:0] s2_sum_ff;
   logic [PROD_W-1:0] s2_prod;

   rsp_item_type     q_wr_item;
   rsp_item_type     q_rd_item;
   queue_status_type q_status;
   logic [QUEUE_CNT_W-1:0] committed;

   // ---------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      case (csr_index)
         CSR_IMAGE_WIDTH: begin
            if (csr_data[CFG_WIDTH_W-1:0] < CFG_WIDTH_W'(3)) begin
               width_last_in = COL_W'(2);
            end else if (csr_data[CFG_WIDTH_W-1:0] > CFG_WIDTH_W'(MAX_WIDTH)) begin
               width_last_in = COL_W'(MAX_WIDTH - 1);
            end else begin
               width_last_in = COL_W'(csr_data[CFG_WIDTH_W-1:0] - CFG_WIDTH_W'(1));
            end
         end
         CSR_IMAGE_HEIGHT: begin
            if (csr_data[CFG_HEIGHT_W-1:0] < CFG_HEIGHT_W'(3)) begin
               height_last_in = ROW_W'(2);
            end else begin
               height_last_in = ROW_W'(csr_data[CFG_HEIGHT_W-1:0] - CFG_HEIGHT_W'(1));
            end
         end
         default: ;
      endcase
   end

   // credit: every item in flight holds a queue slot
   assign committed  = q_status.count + QUEUE_CNT_W'(s1_valid_ff) + QUEUE_CNT_W'(s2_valid_ff);
   assign req_tready = (committed < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   assign last_col = (col_ff == width_last_ff);
   assign last_row = (row_ff == height_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= COL_W'(MAX_WIDTH - 1);
         height_last_ff <= ROW_W'(255);
         col_ff         <= '0;
         row_ff         <= '0;
      end else if (csr_accept) begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         if (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT) begin
            col_ff <= '0;
            row_ff <= '0;
         end
      end else if (req_accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // line buffer read at acceptance, write-back in the next cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_rd_ff  <= upper_mem[col_ff];
         mid_rd_ff <= middle_mem[col_ff];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_col_ff]  <= mid_rd_ff;
         middle_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff       <= col_ff;
         s1_px_ff        <= req_tdata;
         s1_emit_ff      <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
      end
   end

   assign sum_in = SUM_W'(win_ff[0]) + SUM_W'(win_ff[1]) + SUM_W'(win_ff[2])
                 + SUM_W'(win_ff[3]) + SUM_W'(win_ff[4]) + SUM_W'(win_ff[5])
                 + SUM_W'(up_rd_ff) + SUM_W'(mid_rd_ff) + SUM_W'(s1_px_ff);

   // window of the two previous columns, oldest in the low three
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_rd_ff;
         win_ff[4] <= mid_rd_ff;
         win_ff[5] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_sum_ff       <= sum_in;
         s2_row_end_ff   <= s1_row_end_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign s2_prod = PROD_W'(s2_sum_ff) * PROD_W'(RECIP_NINE);

   assign q_wr_item.smoothed  = s2_prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
   assign q_wr_item.row_end   = s2_row_end_ff;
   assign q_wr_item.frame_end = s2_frame_end_ff;

   bxf_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (s2_valid_ff),
      .wr_item  (q_wr_item),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_item  (q_rd_item),
      .status   (q_status)
   );

   assign rsp_tdata    = q_rd_item.smoothed;
   assign rsp_tlast    = q_rd_item.row_end;
   assign rsp_tuser[0] = q_rd_item.frame_end;

   // ---------------------------------------------------------------
   a_queue_never_drops: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !q_status.full)
      else $error("result queue full on write");

   a_no_mem_collision: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_valid_ff) |-> (col_ff != s1_col_ff))
      else $error("line buffer read and write-back hit the same entry");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= width_last_ff)
      else $error("column counter beyond row end");

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("frame end without row end");

endmodule

[rtl/bxf_rsp_queue.sv]
`timescale 1ns / 1ps

module bxf_rsp_queue
   import bxf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  rsp_item_type     wr_item,
   output logic             rd_valid,
   input  logic             rd_ready,
   output rsp_item_type     rd_item,
   output queue_status_type status
);

   rsp_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_wr;
   logic                   do_rd;

   assign do_rd = rd_valid && rd_ready;
   assign do_wr = wr_valid && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_valid     = (count_ff != '0);
   assign rd_item      = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import bxf_pkg::*;

   // expected smoothed pixels for the 3x3 mean, kept in step with the stream
   class mean_scoreboard;
      logic [CFG_WIDTH_W-1:0]  width_reg;
      logic [CFG_HEIGHT_W-1:0] height_reg;
      logic [PIX_W-1:0]        upper_row [MAX_WIDTH];
      logic [PIX_W-1:0]        middle_row [MAX_WIDTH];
      logic [PIX_W-1:0]        window [6];
      int                      col;
      int                      row;
      rsp_item_type            expected_means [$];
      int                      mismatches;
      int                      results_checked;

      function new();
         width_reg       = 9'd256;
         height_reg      = 16'd256;
         col             = 0;
         row             = 0;
         mismatches      = 0;
         results_checked = 0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         for (int i = 0; i < 6; i++) window[i] = '0;
      endfunction

      function int pending();
         return expected_means.size();
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_IMAGE_WIDTH: width_reg = value[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg = value;
            default: return;
         endcase
         // any write restarts the frame, line buffers keep their contents
         col = 0;
         row = 0;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] px);
         int           w;
         int           h;
         int           c;
         int           r;
         int           total;
         logic [7:0]   up;
         logic [7:0]   mid;
         rsp_item_type item;
         w = int'(width_reg);
         if (w < 3) w = 3;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         h = (int'(height_reg) < 3) ? 3 : int'(height_reg);
         c = (col < w) ? col : w - 1;
         r = (row < h) ? row : h - 1;
         up  = upper_row[c];
         mid = middle_row[c];
         upper_row[c]  = mid;
         middle_row[c] = px;
         if (r >= 2 && c >= 2) begin
            total = int'(window[0]) + int'(window[1]) + int'(window[2])
                  + int'(window[3]) + int'(window[4]) + int'(window[5])
                  + int'(up) + int'(mid) + int'(px);
            item.smoothed  = 8'(total / 9);
            item.row_end   = (c == w - 1);
            item.frame_end = (c == w - 1) && (r == h - 1);
            expected_means.push_back(item);
         end
         window[0] = window[3];
         window[1] = window[4];
         window[2] = window[5];
         window[3] = up;
         window[4] = mid;
         window[5] = px;
         if (c == w - 1) begin
            col = 0;
            row = (r == h - 1) ? 0 : r + 1;
         end else begin
            col = c + 1;
            row = r;
         end
      endfunction

      task flag_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         results_checked++;
         if (expected_means.size() == 0) begin
            flag_mismatch($sformatf("result %0d with nothing outstanding", got.smoothed));
            return;
         end
         want = expected_means.pop_front();
         if (got.smoothed !== want.smoothed)
            flag_mismatch($sformatf("result %0d smoothed got %0d want %0d",
                                    results_checked, got.smoothed, want.smoothed));
         if (got.row_end !== want.row_end)
            flag_mismatch($sformatf("result %0d row_end got %b want %b",
                                    results_checked, got.row_end, want.row_end));
         if (got.frame_end !== want.frame_end)
            flag_mismatch($sformatf("result %0d frame_end got %b want %b",
                                    results_checked, got.frame_end, want.frame_end));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;    // [7:0] pixel_in
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;    // [7:0] smoothed
   logic                   rsp_tlast;    // row_end
   logic [0:0]             rsp_tuser;    // [0] frame_end
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   mean_scoreboard sb;
   int             pixels_sent;
   bit             lively;
   bit             calm;
   int             squeeze_requests;
   int             squeeze_served;

   localparam int RANDOM_PIXELS = 1450;
   localparam int CALM_FROM     = 1320;

   box_filter_3x3_mean_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_result(rsp_item_type'({rsp_tuser[0], rsp_tlast, rsp_tdata}));
   end

   // result side: random stalls, one long hold-off on request, none when calm
   initial begin
      int stall_left;
      int squeeze_left;
      stall_left   = 0;
      squeeze_left = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_requests > squeeze_served) begin
            squeeze_served++;
            squeeze_left = 120;
         end
         if (squeeze_left > 0) begin
            squeeze_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (lively && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task send_pixel(logic [7:0] px);
      req_tdata  <= px;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_pixel(px);
      pixels_sent++;
      @(negedge clock);
   endtask

   task maybe_pause_pixels();
      if (lively && !calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // border pixels give no result, so allow for the pipeline to drain too
   task wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task run_frame_set(logic [15:0] width_raw, logic [15:0] height_raw, int count,
                      int squeeze_at);
      logic [7:0] px;
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, width_raw);
      write_csr(CSR_IMAGE_HEIGHT, height_raw);
      lively = ($urandom_range(0, 9) < 7);
      for (int i = 0; i < count; i++) begin
         if (i == squeeze_at) squeeze_requests++;
         if (pixels_sent >= CALM_FROM) calm = 1'b1;
         case ($urandom_range(0, 9))
            0: px = 8'h00;
            1: px = 8'hFF;
            default: px = 8'($urandom_range(0, 255));
         endcase
         send_pixel(px);
         maybe_pause_pixels();
      end
   endtask

   initial begin
      int w;
      int h;
      int count;
      logic [15:0] width_raw;
      logic [15:0] height_raw;
      sb               = new();
      pixels_sent      = 0;
      lively           = 1'b0;
      calm             = 1'b0;
      squeeze_requests = 0;
      squeeze_served   = 0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_IMAGE_WIDTH;
      csr_data         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // smallest frame via saturated width and height, all-white then all-black
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 16'hFE00);
      write_csr(CSR_IMAGE_HEIGHT, 16'h0000);
      repeat (9) send_pixel(8'hFF);
      repeat (9) send_pixel(8'h00);
      repeat (4) send_pixel(8'($urandom_range(0, 255)));

      // one full-width frame, width saturating down to the buffer size
      pixels_sent = 0;
      run_frame_set(16'h01FF, 16'h0003, 3 * MAX_WIDTH, 2 * MAX_WIDTH + 20);

      while (pixels_sent < RANDOM_PIXELS) begin
         w          = $urandom_range(3, 12);
         h          = $urandom_range(3, 8);
         width_raw  = {7'($urandom), 9'(w)};
         height_raw = 16'(h);
         count      = -1;
         case ($urandom_range(0, 9))
            0: begin
               w         = 3;
               width_raw = {7'($urandom), 9'($urandom_range(0, 2))};
            end
            1: begin
               h          = 3;
               height_raw = 16'($urandom_range(0, 2));
            end
            2: begin
               height_raw = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1000, 65534));
               count      = w * $urandom_range(3, 12);
            end
            default: ;
         endcase
         if (count < 0)
            count = w * h * $urandom_range(1, 2) + $urandom_range(0, w * h - 1);
         run_frame_set(width_raw, height_raw, count, -1);
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
